### hdl/bscff_pkg.sv
// Shared constants, codes and control structs for the bit map set/clear/find block.
// No dependencies; every other file of the block depends on it.
`default_nettype none

package bscff_pkg;

  localparam int MAX_BITS   = 1024;
  localparam int WORD_BITS  = 32;
  localparam int MAP_DEPTH  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int INDEX_W    = $clog2(MAX_BITS);
  localparam int LIM_W      = INDEX_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int OPCODE_W   = 3;
  localparam int CFG_W      = 11;

  localparam logic [CFG_W-1:0] ACTIVE_BITS_RESET = CFG_W'(1024);

  localparam logic [OPCODE_W-1:0] OP_SET       = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_TEST      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_FIND_ZERO = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FIND_ONE  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR_ALL = 3'd5;

  typedef enum logic [1:0] {
    CL_RMW,
    CL_SEARCH,
    CL_CLEAR,
    CL_NOP
  } op_class_t;

  typedef struct packed {
    logic load;       // transfer in: latch the item and issue the first map read
    logic step;       // issue the next scan read
    logic rmw;        // write back or test the word read for a single-bit op
    logic capture;    // capture the search result from the word in hand
    logic clear_all;  // drop every map word
    logic push;       // move the result into the output register
  } cmd_t;

  typedef struct packed {
    op_class_t in_class;
    logic      hit;
    logic      last;
    logic      out_free;
  } status_t;

  function automatic op_class_t classify(input logic [OPCODE_W-1:0] op);
    op_class_t c;
    case (op)
      OP_SET, OP_CLEAR, OP_TEST:  c = CL_RMW;
      OP_FIND_ZERO, OP_FIND_ONE:  c = CL_SEARCH;
      OP_CLEAR_ALL:               c = CL_CLEAR;
      default:                    c = CL_NOP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/bscff_if.sv
// Valid/ready channel interfaces for the bit map block: request and response.
// Depends on bscff_pkg for field widths.
`default_nettype none

interface bscff_req_if;
  logic                            valid;
  logic                            ready;
  logic [bscff_pkg::OPCODE_W-1:0]  opcode;
  logic [bscff_pkg::INDEX_W-1:0]   bit_index;

  modport source (output valid, output opcode, output bit_index, input ready);
  modport sink   (input valid, input opcode, input bit_index, output ready);
endinterface

interface bscff_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            test_value;
  logic                            found;
  logic [bscff_pkg::INDEX_W-1:0]   found_index;

  modport source (output valid, output test_value, output found, output found_index,
                  input ready);
  modport sink   (input valid, input test_value, input found, input found_index,
                  output ready);
endinterface

`default_nettype wire

### hdl/bscff_dp.sv
// Datapath: map word memory with per-word valid bits, active size register,
// scan evaluation, result and output registers. Depends on bscff_pkg.
`default_nettype none

module bscff_dp (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [bscff_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire  [bscff_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire  [bscff_pkg::INDEX_W-1:0]    in_bit_index,
  input  wire  bscff_pkg::cmd_t            cmd,
  output bscff_pkg::status_t               status,
  input  wire                              out_ready,
  output logic                             out_valid,
  output logic                             out_test_value,
  output logic                             out_found,
  output logic [bscff_pkg::INDEX_W-1:0]    out_found_index
);
  import bscff_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_DEPTH];
  logic                 vbits [MAP_DEPTH];

  logic [CFG_W-1:0]     active_bits;
  logic [OPCODE_W-1:0]  op_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [WADDR_W-1:0]   ptr;
  logic [WADDR_W-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rdata;
  logic                 rvalid;

  logic                 res_tv;
  logic                 res_found;
  logic [INDEX_W-1:0]   res_index;

  logic [LIM_W-1:0]     lim;
  logic                 rd_en;
  logic [WADDR_W-1:0]   raddr;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] scan_word;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     bit_pos;
  logic [LIM_W-1:0]     base;
  logic [LIM_W-1:0]     base_next;
  logic [LIM_W-1:0]     rem;
  logic                 in_range;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] wdata;
  logic                 wr_en;
  logic                 out_free;

  assign lim = (active_bits > CFG_W'(MAX_BITS)) ? LIM_W'(MAX_BITS) : LIM_W'(active_bits);

  // Read address: single-bit ops read their own word, searches start at word 0.
  assign rd_en = cmd.load | cmd.step;
  always_comb begin
    if (cmd.load) begin
      if (classify(in_opcode) == CL_SEARCH) begin
        raddr = '0;
      end else begin
        raddr = WADDR_W'(in_bit_index >> BIT_W);
      end
    end else begin
      raddr = ptr;
    end
  end

  // Words never written since reset or clear all read as zero.
  assign word = rvalid ? rdata : '0;

  // Scan evaluation of the word in hand, limited to bits below the active size.
  assign base      = LIM_W'(rd_addr) << BIT_W;
  assign base_next = (LIM_W'(rd_addr) + LIM_W'(1)) << BIT_W;
  assign rem       = lim - base;
  always_comb begin
    if (lim <= base) begin
      mask = '0;
    end else if (rem >= LIM_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
    end
  end

  assign scan_word = (op_q == OP_FIND_ONE) ? word : ~word;
  assign masked    = scan_word & mask;
  assign lowest    = masked & (~masked + WORD_BITS'(1));

  always_comb begin
    bit_pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        bit_pos = bit_pos | BIT_W'(i);
      end
    end
  end

  // Single-bit ops.
  assign in_range = LIM_W'(idx_q) < lim;
  assign bit_mask = WORD_BITS'(1) << idx_q[BIT_W-1:0];
  assign wdata    = (op_q == OP_SET) ? (word | bit_mask) : (word & ~bit_mask);
  assign wr_en    = cmd.rmw & in_range & ((op_q == OP_SET) | (op_q == OP_CLEAR));

  assign out_free = ~out_valid | out_ready;

  always_comb begin
    status.in_class = classify(in_opcode);
    status.hit      = |masked;
    status.last     = (rd_addr == WADDR_W'(MAP_DEPTH - 1)) || (base_next >= lim);
    status.out_free = out_free;
  end

  // Map memory.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (wr_en) begin
      mem[WADDR_W'(idx_q >> BIT_W)] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < MAP_DEPTH; i++) begin
        vbits[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vbits[WADDR_W'(idx_q >> BIT_W)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rvalid  <= vbits[raddr];
      rd_addr <= raddr;
    end
    if (cmd.load) begin
      op_q  <= in_opcode;
      idx_q <= in_bit_index;
      ptr   <= WADDR_W'(1);
    end else if (cmd.step) begin
      ptr <= ptr + WADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits <= ACTIVE_BITS_RESET;
    end else if (cfg_we) begin
      active_bits <= cfg_wdata;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_tv    <= 1'b0;
      res_found <= 1'b0;
      res_index <= '0;
    end else begin
      if (cmd.rmw && op_q == OP_TEST) begin
        res_tv <= in_range & word[idx_q[BIT_W-1:0]];
      end
      if (cmd.capture && status.hit) begin
        res_found <= 1'b1;
        res_index <= INDEX_W'({rd_addr, bit_pos});
      end
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_test_value  <= res_tv;
      out_found       <= res_found;
      out_found_index <= res_index;
    end
  end

endmodule

`default_nettype wire

### hdl/bscff_ctrl.sv
// Controller state machine: sequences accept, read-modify-write, word scan and
// result hand-off for the bit map datapath. Depends on bscff_pkg.
`default_nettype none

module bscff_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire bscff_pkg::status_t  status,
  output bscff_pkg::cmd_t          cmd
);
  import bscff_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (status.in_class)
            CL_RMW:    state_next = S_RMW;
            CL_SEARCH: state_next = S_SCAN;
            CL_CLEAR: begin
              cmd.clear_all = 1'b1;
              state_next    = S_DONE;
            end
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RMW: begin
        cmd.rmw    = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        // Stop on the first word with a match or at the last word in range.
        if (status.hit || status.last) begin
          cmd.capture = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/bitmap_set_clear_find_first.sv
// Top level of the bit map set/clear/find block: controller plus datapath.
// Depends on bscff_pkg, bscff_if, bscff_ctrl and bscff_dp.
//
// A map of 1024 bits held as 32 words of 32 bits in a single-port memory, cleared
// at reset and by clear all through per-word valid bits, so there is no clearing
// pass. One request is in work at a time and each gives one response. Set, clear
// and test read the word, then modify or test it, then load the output register;
// clear all and unused codes go straight to loading the output register. A search
// reads one map word per cycle and stops at the first word with a match or at the
// last word below the active size. The output register lets a response wait while
// the next request is taken. active_bits may be written only while the block is
// idle; values above 1024 act as 1024.
`default_nettype none

module bitmap_set_clear_find_first (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [bscff_pkg::CFG_W-1:0]  cfg_wdata,
  bscff_req_if.sink                    request,
  bscff_rsp_if.source                  response
);
  import bscff_pkg::*;

  cmd_t    cmd;
  status_t status;

  bscff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bscff_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (request.opcode),
    .in_bit_index    (request.bit_index),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (response.ready),
    .out_valid       (response.valid),
    .out_test_value  (response.test_value),
    .out_found       (response.found),
    .out_found_index (response.found_index)
  );

endmodule

`default_nettype wire

### bench/bitmap_set_clear_find_first_test.sv
// Self-checking bench for bitmap_set_clear_find_first: directed and random bit map ops.
// Depends on bscff_pkg, bscff_if and the block itself; a tracker class predicts
// every response.
`default_nettype none

module bitmap_set_clear_find_first_test;
  import bscff_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 250_000;
  localparam int DRAIN_WAIT  = 40;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic               test_value;
    logic               found;
    logic [INDEX_W-1:0] found_index;
  } bitmap_result_t;

  class bitmap_tracker;
    logic [WORD_BITS-1:0] words [MAP_DEPTH];
    int unsigned          active;
    bitmap_result_t       pending_results [$];
    int unsigned          mismatches;

    function new();
      foreach (words[i]) words[i] = '0;
      active     = ACTIVE_BITS_RESET;
      mismatches = 0;
    endfunction

    function void set_active(logic [CFG_W-1:0] value);
      active = value;
    endfunction

    function int unsigned limit();
      return (active > MAX_BITS) ? MAX_BITS : active;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void take_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx);
      bitmap_result_t r;
      int unsigned    lim;
      int unsigned    w;
      int unsigned    b;
      int unsigned    p;
      logic           in_range;
      logic           want;
      r        = '0;
      lim      = limit();
      in_range = (idx < lim);
      w        = idx / WORD_BITS;
      b        = idx % WORD_BITS;
      case (op)
        OP_SET:   if (in_range) words[w][b] = 1'b1;
        OP_CLEAR: if (in_range) words[w][b] = 1'b0;
        OP_TEST:  if (in_range) r.test_value = words[w][b];
        OP_FIND_ZERO, OP_FIND_ONE: begin
          want = (op == OP_FIND_ONE);
          for (p = 0; p < lim && !r.found; p++) begin
            if (words[p / WORD_BITS][p % WORD_BITS] == want) begin
              r.found       = 1'b1;
              r.found_index = INDEX_W'(p);
            end
          end
        end
        OP_CLEAR_ALL: foreach (words[i]) words[i] = '0;
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_response(logic tv, logic fnd, logic [INDEX_W-1:0] fidx);
      bitmap_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response test_value=%0b found=%0b found_index=%0d",
                 $time, tv, fnd, fidx);
        mismatches++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (tv !== exp_r.test_value || fnd !== exp_r.found ||
          fidx !== exp_r.found_index) begin
        $display("%0t: response mismatch expected test_value=%0b found=%0b found_index=%0d",
                 $time, exp_r.test_value, exp_r.found, exp_r.found_index);
        $display("%0t:   actual test_value=%0b found=%0b found_index=%0d",
                 $time, tv, fnd, fidx);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          cycle_count;
  bitmap_tracker        tracker = new();

  bscff_req_if req_ch ();
  bscff_rsp_if rsp_ch ();

  bitmap_set_clear_find_first dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .request  (req_ch),
    .response (rsp_ch)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_set_clear_find_first test failed");
      $finish;
    end
  end

  initial rsp_ch.ready = 1'b0;
  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_response(rsp_ch.test_value, rsp_ch.found, rsp_ch.found_index);
  end

  // Caller sits at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.opcode    = op;
    req_ch.bit_index = idx;
    do @(posedge clk); while (!req_ch.ready);
    tracker.take_request(op, idx);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_active(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_active(value);
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned lim;
    int unsigned roll;
    lim  = tracker.limit();
    roll = $urandom_range(9);
    if (lim != 0 && roll < 8)
      return INDEX_W'($urandom_range(lim - 1));
    if (lim < MAX_BITS && roll == 8)
      return INDEX_W'(lim);
    return INDEX_W'($urandom_range(MAX_BITS - 1));
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return OP_SET;
    if (roll < 50) return OP_CLEAR;
    if (roll < 68) return OP_TEST;
    if (roll < 80) return OP_FIND_ZERO;
    if (roll < 92) return OP_FIND_ONE;
    if (roll < 95) return OP_CLEAR_ALL;
    return $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_request(pick_opcode(), pick_index());
  endtask

  // Fill the active range in order, probing both searches as the boundary moves.
  task automatic fill_sweep();
    int unsigned i;
    for (i = 0; i < tracker.limit(); i++) begin
      send_request(OP_SET, INDEX_W'(i));
      if (i % 6 == 5) begin
        send_request(OP_FIND_ZERO, pick_index());
        send_request(OP_FIND_ONE, pick_index());
      end
    end
    send_request(OP_FIND_ZERO, '0);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size, input int unsigned idle,
                           input int unsigned stall, input int unsigned count);
    write_active(size);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    run_random(count);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_SET;
    req_ch.bit_index = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    cycle_count      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty map searches, extreme indexes, unused codes, size changes.
    send_request(OP_FIND_ZERO, '0);
    send_request(OP_FIND_ONE, '1);
    send_request(OP_SET, '0);
    send_request(OP_SET, '1);
    send_request(OP_TEST, '1);
    send_request(OP_FIND_ONE, '0);
    send_request(OP_FIND_ZERO, '1);
    send_request(OP_CLEAR, '0);
    send_request(OP_FIND_ONE, '0);
    send_request(OP_UNUSED_LO, '1);
    send_request(OP_UNUSED_HI, '0);
    send_request(OP_SET, INDEX_W'(500));
    write_active(CFG_W'(10));
    send_request(OP_SET, INDEX_W'(10));
    send_request(OP_TEST, '1);
    send_request(OP_SET, INDEX_W'(9));
    send_request(OP_FIND_ONE, '0);
    send_request(OP_CLEAR, '1);
    write_active('0);
    send_request(OP_FIND_ZERO, '0);
    send_request(OP_FIND_ONE, '0);
    send_request(OP_TEST, '0);
    write_active(CFG_W'(1024));
    send_request(OP_TEST, '1);
    send_request(OP_TEST, INDEX_W'(10));
    send_request(OP_CLEAR_ALL, '1);
    send_request(OP_TEST, INDEX_W'(500));
    send_request(OP_FIND_ONE, '0);

    run_phase(CFG_W'(1024), 0, 0, 40);
    write_active(CFG_W'(96));
    send_idle_pct = 66;
    fill_sweep();
    run_random(30);
    run_phase(CFG_W'(33), 0, 66, 70);
    run_phase('1, 36, 36, 40);
    run_phase(CFG_W'(1), 0, 0, 20);
    run_phase(CFG_W'($urandom_range(2047)), 36, 36, 50);

    wait_idle();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0)
      $display("bitmap_set_clear_find_first test passed");
    else
      $display("bitmap_set_clear_find_first test failed");
    $finish;
  end

endmodule

`default_nettype wire
